// ----- rtl/rcc_pkg.sv -----
// Shared constants and status codes of the range encoder with carry cache.
`default_nettype none
package rcc_pkg;

  localparam int FREQ_W     = 24;  // width of the cumulative frequencies
  localparam int PEND_W     = 32;  // width of the pending byte counter
  localparam int RANGE_W    = 32;
  localparam int LOW_W      = RANGE_W + 1;
  localparam int CNT_W      = 32;  // width of fill_count
  localparam int DIV_CNT_W  = $clog2(RANGE_W + 1);

  localparam logic [RANGE_W-1:0] RANGE_INIT = 32'hFFFF_FFFF;
  localparam logic [RANGE_W-1:0] LOW_TOP    = 32'hFF00_0000;
  localparam logic [CNT_W-1:0]   CNT_MAX    = 32'hFFFF_FFFF;
  localparam logic [PEND_W-1:0]  PEND_MAX   = {PEND_W{1'b1}};

  // Item kinds on the input tuser
  localparam logic [1:0] OP_ENCODE = 2'd0;
  localparam logic [1:0] OP_FINISH = 2'd1;
  localparam logic [1:0] OP_START  = 2'd2;

  // Result status on the output tuser
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_ZERO_TOT  = 2'd1;
  localparam logic [1:0] STAT_UNDERFLOW = 2'd2;
  localparam logic [1:0] STAT_PEND_OVF  = 2'd3;

  // Divider handshake
  typedef struct packed {
    logic busy;
    logic done;
  } rcc_div_stat_t;

endpackage
`default_nettype wire

// ----- rtl/rcc_div.sv -----
// Restoring radix-2 divider: 32-bit range by a frequency total, one bit per cycle.
`default_nettype none
module rcc_div import rcc_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic [RANGE_W-1:0] dividend_i,
  input  wire logic [FREQ_W-1:0]  divisor_i,
  output rcc_div_stat_t           stat_o,
  output logic      [RANGE_W-1:0] quot_o
);

  logic [FREQ_W:0]    rem_q, rem_d, rem_sh;
  logic [RANGE_W-1:0] quo_q, quo_d;
  logic [FREQ_W-1:0]  dvs_q, dvs_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic               busy_q, busy_d, done_q, done_d;
  logic               ge;

  always_comb begin
    rem_sh = {rem_q[FREQ_W-1:0], quo_q[RANGE_W-1]};
    ge     = rem_sh >= {1'b0, dvs_q};
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
      cnt_d  = DIV_CNT_W'(RANGE_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? rem_sh - {1'b0, dvs_q} : rem_sh;
      quo_d = {quo_q[RANGE_W-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quot_o      = quo_q;

endmodule
`default_nettype wire

// ----- rtl/range_encoder_carry_cache.sv -----
// Top level: carry-safe byte range encoder with cache byte and pending run count.
// Sequence: an encode item is accepted, divided bit-serially (start, steps, done), multiplied
//   in MUL1 to MUL3, then shifts out up to four bytes, exits the loop and drains the held result;
//   finish shifts five bytes, exits and drains; zero total and zero quotient give one error result.
// Items: one at a time, input ready only while idle; output stalls hold the shift, flush and error states.
// Reset: rst_ni async active low; low 0, range all ones, cache 0, pending count 1.
`default_nettype none
module range_encoder_carry_cache import rcc_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input stream
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [71:0] s_axis_tdata_i,  // sym_low[23:0], sym_high[47:24], sym_total[71:48]
  input  wire logic [1:0]  s_axis_tuser_i,  // op[1:0]
  // result stream
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [47:0]      m_axis_tdata_o,  // lead_byte[7:0], fill_byte[15:8], fill_count[47:16]
  output logic [1:0]       m_axis_tuser_o,  // status[1:0]
  output logic             m_axis_tlast_o   // last result of the item
);

  // Sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIV   = 3'd1;  // r = range / total
  localparam logic [2:0] S_MUL1  = 3'd2;  // r * low
  localparam logic [2:0] S_MUL2  = 3'd3;  // low update, range - r*low, r * (high - low)
  localparam logic [2:0] S_MUL3  = 3'd4;  // pick new range
  localparam logic [2:0] S_SHIFT = 3'd5;  // one byte shift per cycle while the held result can move on
  localparam logic [2:0] S_FLUSH = 3'd6;  // release held result as last
  localparam logic [2:0] S_ERR   = 3'd7;  // single error result

  logic [2:0] state_q, state_d;

  // Coder state
  logic [LOW_W-1:0]   low_q, low_d;
  logic [RANGE_W-1:0] range_q, range_d;
  logic [7:0]         cache_q, cache_d;
  logic [PEND_W-1:0]  pend_q, pend_d;

  // Item registers
  logic [FREQ_W-1:0]  lo_q, lo_d, hi_q, hi_d, tot_q, tot_d;
  logic               fin_q, fin_d;
  logic [2:0]         cnt_q, cnt_d;
  logic [1:0]         err_q, err_d;
  logic [RANGE_W-1:0] r_q, r_d;
  logic [63:0]        mult_q, mult_d;

  // Held result: we only learn it is the last one when the loop ends.
  logic               hold_v_q, hold_v_d;
  logic [7:0]         hold_lead_q, hold_lead_d, hold_fill_q, hold_fill_d;
  logic [CNT_W-1:0]   hold_cnt_q, hold_cnt_d;
  logic [1:0]         hold_stat_q, hold_stat_d;

  // Output register
  logic               out_v_q, out_v_d, out_last_q, out_last_d;
  logic [7:0]         out_lead_q, out_lead_d, out_fill_q, out_fill_d;
  logic [CNT_W-1:0]   out_cnt_q, out_cnt_d;
  logic [1:0]         out_stat_q, out_stat_d;

  // Divider
  rcc_div_stat_t      div_stat;
  logic [RANGE_W-1:0] div_quot;
  logic               div_start;

  rcc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (range_q),
    .divisor_i  (tot_q),
    .stat_o     (div_stat),
    .quot_o     (div_quot)
  );

  logic               in_xfer, out_free;
  logic [RANGE_W-1:0] diff32, mul_b, low32;
  logic               carry, sh_release, sh_sat, sh_more, sh_go;
  logic [PEND_W-1:0]  fills_full;
  logic [CNT_W-1:0]   fills;

  assign in_xfer  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !out_v_q || m_axis_tready_i;

  // Shared multiplier operand: symbol low, then the interval width (wraps mod 2^32)
  assign diff32 = {{(RANGE_W-FREQ_W){1'b0}}, hi_q} - {{(RANGE_W-FREQ_W){1'b0}}, lo_q};
  assign mul_b  = (state_q == S_MUL1) ? {{(RANGE_W-FREQ_W){1'b0}}, lo_q} : diff32;

  // Byte shift decision
  assign low32      = low_q[RANGE_W-1:0];
  assign carry      = low_q[LOW_W-1];
  assign sh_release = (low32 < LOW_TOP) || carry;
  assign sh_sat     = !sh_release && (pend_q == PEND_MAX);
  assign fills_full = (pend_q != '0) ? pend_q - 1'b1 : '0;
  assign fills      = (fills_full > PEND_W'(CNT_MAX)) ? CNT_MAX : CNT_W'(fills_full);
  // Finish: five shifts. Encode: up to four, while range < 2^24.
  assign sh_more    = fin_q ? (cnt_q < 3'd5) : ((range_q[31:24] == 8'd0) && (cnt_q < 3'd4));
  // A new result may push the held one out, so wait for room first
  assign sh_go      = !hold_v_q || out_free;

  always_comb begin
    state_d     = state_q;
    low_d       = low_q;
    range_d     = range_q;
    cache_d     = cache_q;
    pend_d      = pend_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    tot_d       = tot_q;
    fin_d       = fin_q;
    cnt_d       = cnt_q;
    err_d       = err_q;
    r_d         = r_q;
    mult_d      = mult_q;
    hold_v_d    = hold_v_q;
    hold_lead_d = hold_lead_q;
    hold_fill_d = hold_fill_q;
    hold_cnt_d  = hold_cnt_q;
    hold_stat_d = hold_stat_q;
    out_v_d     = out_v_q && !m_axis_tready_i;
    out_last_d  = out_last_q;
    out_lead_d  = out_lead_q;
    out_fill_d  = out_fill_q;
    out_cnt_d   = out_cnt_q;
    out_stat_d  = out_stat_q;
    div_start   = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          lo_d  = s_axis_tdata_i[23:0];
          hi_d  = s_axis_tdata_i[47:24];
          tot_d = s_axis_tdata_i[71:48];
          cnt_d = '0;
          case (s_axis_tuser_i)
            OP_ENCODE: begin
              fin_d = 1'b0;
              if (s_axis_tdata_i[71:48] == '0) begin
                err_d   = STAT_ZERO_TOT;
                state_d = S_ERR;
              end else begin
                state_d = S_DIV;
              end
            end
            OP_FINISH: begin
              fin_d   = 1'b1;
              state_d = S_SHIFT;
            end
            OP_START: begin
              low_d   = '0;
              range_d = RANGE_INIT;
              cache_d = '0;
              pend_d  = PEND_W'(1);
            end
            default: ;
          endcase
        end
      end
      S_DIV: begin
        // tot_q is loaded at the accept edge; kick the divider in the cycle after it
        div_start = !div_stat.busy && !div_stat.done && (cnt_q == 3'd0);
        if (div_start) begin
          cnt_d = 3'd1;
        end
        if (div_stat.done) begin
          r_d = div_quot;
          if (div_quot == '0) begin
            err_d   = STAT_UNDERFLOW;
            state_d = S_ERR;
          end else begin
            state_d = S_MUL1;
          end
        end
      end
      S_MUL1: begin
        mult_d  = r_q * mul_b;
        state_d = S_MUL2;
      end
      S_MUL2: begin
        low_d   = low_q + mult_q[LOW_W-1:0];
        range_d = range_q - mult_q[RANGE_W-1:0];
        mult_d  = r_q * mul_b;
        state_d = S_MUL3;
      end
      S_MUL3: begin
        if (hi_q < tot_q) begin
          range_d = mult_q[RANGE_W-1:0];
        end
        cnt_d   = '0;
        state_d = S_SHIFT;
      end
      S_SHIFT: begin
        if (!sh_more) begin
          state_d = S_FLUSH;
        end else if (sh_go) begin
          cnt_d = cnt_q + 1'b1;
          if (!fin_q) begin
            range_d = {range_q[RANGE_W-9:0], 8'd0};
          end
          if (sh_release || sh_sat) begin
            if (hold_v_q) begin
              out_v_d    = 1'b1;
              out_last_d = 1'b0;
              out_lead_d = hold_lead_q;
              out_fill_d = hold_fill_q;
              out_cnt_d  = hold_cnt_q;
              out_stat_d = hold_stat_q;
            end
            hold_v_d = 1'b1;
          end
          if (sh_release) begin
            hold_lead_d = cache_q + {7'd0, carry};
            hold_fill_d = 8'hFF + {7'd0, carry};
            hold_cnt_d  = fills;
            hold_stat_d = STAT_OK;
            cache_d     = low32[31:24];
            pend_d      = PEND_W'(1);
          end else if (sh_sat) begin
            hold_lead_d = '0;
            hold_fill_d = '0;
            hold_cnt_d  = '0;
            hold_stat_d = STAT_PEND_OVF;
          end else begin
            pend_d = pend_q + 1'b1;
          end
          low_d = {1'b0, low32[23:0], 8'd0};
        end
      end
      S_FLUSH: begin
        if (!hold_v_q) begin
          state_d = S_IDLE;
        end else if (out_free) begin
          out_v_d    = 1'b1;
          out_last_d = 1'b1;
          out_lead_d = hold_lead_q;
          out_fill_d = hold_fill_q;
          out_cnt_d  = hold_cnt_q;
          out_stat_d = hold_stat_q;
          hold_v_d   = 1'b0;
          state_d    = S_IDLE;
        end
      end
      S_ERR: begin
        if (out_free) begin
          out_v_d    = 1'b1;
          out_last_d = 1'b1;
          out_lead_d = '0;
          out_fill_d = '0;
          out_cnt_d  = '0;
          out_stat_d = err_q;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      low_q    <= '0;
      range_q  <= RANGE_INIT;
      cache_q  <= '0;
      pend_q   <= PEND_W'(1);
      fin_q    <= 1'b0;
      cnt_q    <= '0;
      hold_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      low_q    <= low_d;
      range_q  <= range_d;
      cache_q  <= cache_d;
      pend_q   <= pend_d;
      fin_q    <= fin_d;
      cnt_q    <= cnt_d;
      hold_v_q <= hold_v_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q        <= lo_d;
    hi_q        <= hi_d;
    tot_q       <= tot_d;
    err_q       <= err_d;
    r_q         <= r_d;
    mult_q      <= mult_d;
    hold_lead_q <= hold_lead_d;
    hold_fill_q <= hold_fill_d;
    hold_cnt_q  <= hold_cnt_d;
    hold_stat_q <= hold_stat_d;
    out_last_q  <= out_last_d;
    out_lead_q  <= out_lead_d;
    out_fill_q  <= out_fill_d;
    out_cnt_q   <= out_cnt_d;
    out_stat_q  <= out_stat_d;
  end

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = {out_cnt_q, out_fill_q, out_lead_q};
  assign m_axis_tuser_o  = out_stat_q;
  assign m_axis_tlast_o  = out_last_q;

  // Checks
  a_idle_no_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> !hold_v_q)
    else $error("held result left behind at end of item");

  a_pend_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q != '0)
    else $error("pending count reached zero");

  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> (state_q == S_DIV))
    else $error("divider finished outside the divide state");

  a_shift_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SHIFT) |-> (cnt_q <= 3'd5))
    else $error("shift count past its bound");

  a_err_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ERR && out_free) |=> (out_v_q && out_last_q))
    else $error("error result not marked last");

endmodule
`default_nettype wire

// ----- verif/range_encoder_carry_cache_tb.sv -----
// Self-checking testbench for the carry-safe range encoder with cache byte.
`timescale 1ns / 100ps
`default_nettype none
module range_encoder_carry_cache_tb;
  import rcc_pkg::*;

  localparam int                 WATCHDOG_LIMIT = 2000;  // cycles without any transfer
  localparam int                 ITEM_TARGET    = 430;
  localparam logic [RANGE_W-1:0] RANGE_TOP      = 32'h0100_0000;
  localparam logic [1:0]         OP_UNKNOWN     = 2'd3;  // undefined item kind

  // One released run (or error report) as seen on the result stream
  typedef struct {
    logic [7:0]       lead;
    logic [7:0]       fill;
    logic [CNT_W-1:0] count;
    logic [1:0]       status;
    logic             last;
  } run_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic        s_tvalid = 1'b0;
  logic [71:0] s_tdata  = '0;
  logic [1:0]  s_tuser  = OP_ENCODE;
  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic        m_tready = 1'b0;
  logic [47:0] m_axis_tdata_o;
  logic [1:0]  m_axis_tuser_o;
  logic        m_axis_tlast_o;

  always #6 clk_i = ~clk_i;

  range_encoder_carry_cache uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  // ---------------------------------------------------------------------------
  // Coder state mirror and the runs it predicts
  // ---------------------------------------------------------------------------
  logic [LOW_W-1:0]   cod_low   = '0;
  logic [RANGE_W-1:0] cod_range = RANGE_INIT;
  logic [7:0]         cod_cache = '0;
  logic [PEND_W-1:0]  cod_pend  = 1;

  run_t pred_runs[$];  // runs still to come out of the block, oldest first
  run_t item_runs[$];  // runs caused by the item being predicted
  int   errors     = 0;
  int   items_sent = 0;

  function automatic void push_status(logic [1:0] status);
    run_t r;
    r.lead   = '0;
    r.fill   = '0;
    r.count  = '0;
    r.status = status;
    r.last   = 1'b0;
    item_runs.push_back(r);
  endfunction

  // One byte leaves low; a run is released unless the byte may still take a carry.
  function automatic void shift_out_byte();
    logic [31:0] low32;
    logic        carry;
    logic [63:0] fills;
    run_t        r;
    low32 = cod_low[31:0];
    carry = cod_low[32];
    if (low32 < LOW_TOP || carry) begin
      fills = (cod_pend > 0) ? 64'(cod_pend) - 64'd1 : 64'd0;
      if (fills > 64'(CNT_MAX))
        fills = 64'(CNT_MAX);
      r.lead   = cod_cache + {7'd0, carry};
      r.fill   = 8'hFF + {7'd0, carry};   // carry turns the 0xFF fill into 0x00
      r.count  = fills[CNT_W-1:0];
      r.status = STAT_OK;
      r.last   = 1'b0;
      item_runs.push_back(r);
      cod_cache = low32[31:24];
      cod_pend  = 1;
    end else if (cod_pend >= PEND_MAX) begin
      cod_pend = PEND_MAX;
      push_status(STAT_PEND_OVF);
    end else begin
      cod_pend = cod_pend + 1;
    end
    cod_low = {1'b0, low32[23:0], 8'h00};
  endfunction

  function automatic void code_item(logic [1:0] op, logic [23:0] lo, logic [23:0] hi,
                                    logic [23:0] tot);
    logic [31:0] quot;
    logic [63:0] prod;
    logic [31:0] width;
    int          steps;
    item_runs.delete();
    case (op)
      OP_START: begin
        cod_low   = '0;
        cod_range = RANGE_INIT;
        cod_cache = '0;
        cod_pend  = 1;
      end
      OP_FINISH: begin
        repeat (5) shift_out_byte();
      end
      OP_ENCODE: begin
        if (tot == 0) begin
          push_status(STAT_ZERO_TOT);
        end else begin
          quot = cod_range / {8'd0, tot};
          if (quot == 0) begin
            push_status(STAT_UNDERFLOW);
          end else begin
            prod    = {32'd0, quot} * {40'd0, lo};
            cod_low = cod_low + prod[LOW_W-1:0];
            if (hi < tot) begin
              width     = {8'd0, hi} - {8'd0, lo};
              cod_range = quot * width;
            end else begin
              cod_range = cod_range - prod[31:0];
            end
            // a range that wrapped to zero stops after four shifts
            steps = 0;
            while (cod_range < RANGE_TOP && steps < 4) begin
              cod_range = cod_range << 8;
              shift_out_byte();
              steps++;
            end
          end
        end
      end
      default: ;  // unknown kind: ignored
    endcase
    if (item_runs.size() > 0)
      item_runs[item_runs.size()-1].last = 1'b1;
    foreach (item_runs[i])
      pred_runs.push_back(item_runs[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: bursts of random length separated by random gaps
  // ---------------------------------------------------------------------------
  int burst_left = 0;
  bit sender_eager = 1'b0;  // no gaps while set

  task automatic send_item(logic [1:0] op, logic [23:0] lo, logic [23:0] hi,
                           logic [23:0] tot);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      gap = sender_eager ? 0 : $urandom_range(0, 20);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= {tot, hi, lo};
    s_tuser  <= op;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    code_item(op, lo, hi, tot);
    if (op != OP_UNKNOWN)
      items_sent++;
  endtask

  task automatic send_symbol();
    logic [23:0] tot;
    logic [23:0] lo;
    logic [23:0] hi;
    int          sel;
    sel = $urandom_range(0, 9);
    if (sel < 5)
      tot = 24'($urandom_range(2, 256));
    else if (sel < 8)
      tot = 24'($urandom_range(257, 65535));
    else
      tot = 24'($urandom_range(65536, 24'hFF_FFFF));
    if ($urandom_range(0, 9) == 0) begin
      // top symbol pushes low toward the window top: long 0xFF runs and carries
      lo = tot - 24'd1;
      hi = tot;
    end else begin
      lo = 24'($urandom_range(0, tot - 1));
      hi = 24'($urandom_range(lo + 1, tot));
    end
    send_item(OP_ENCODE, lo, hi, tot);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver stalls: mode changes now and then; the stall modes drop tready in randomly chosen cycles
  // ---------------------------------------------------------------------------
  int rx_mode      = 0;
  int rx_mode_left = 0;
  int rx_stall     = 0;

  always @(posedge clk_i) begin
    if (rx_mode_left == 0) begin
      rx_mode      = $urandom_range(0, 2);
      rx_mode_left = $urandom_range(16, 96);
    end else begin
      rx_mode_left--;
    end
    if (rx_stall > 0) begin
      rx_stall--;
      m_tready <= 1'b0;
    end else if ((rx_mode == 1 && $urandom_range(0, 7) == 0) ||
                 (rx_mode == 2 && $urandom_range(0, 1) == 0)) begin
      rx_stall = $urandom_range(0, 14);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Result check and watchdog
  // ---------------------------------------------------------------------------
  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endfunction

  int idle_cycles = 0;

  always @(posedge clk_i) begin : check_results
    run_t want;
    if (rst_ni && m_axis_tvalid_o && m_tready) begin
      if (pred_runs.size() == 0) begin
        $error("result transfer with nothing expected: tdata %0h", m_axis_tdata_o);
        errors++;
      end else begin
        want = pred_runs.pop_front();
        check_field("lead_byte", 32'(want.lead), 32'(m_axis_tdata_o[7:0]));
        check_field("fill_byte", 32'(want.fill), 32'(m_axis_tdata_o[15:8]));
        check_field("fill_count", want.count, m_axis_tdata_o[47:16]);
        check_field("status", 32'(want.status), 32'(m_axis_tuser_o));
        check_field("last", 32'(want.last), 32'(m_axis_tlast_o));
      end
    end
    if ((m_axis_tvalid_o && m_tready) || (s_tvalid && s_axis_tready_o)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_basic_frame();
    send_item(OP_START, '0, '0, '0);
    send_item(OP_ENCODE, 24'd0, 24'd1, 24'd2);
    send_item(OP_ENCODE, 24'd100, 24'd300, 24'd1000);
    send_item(OP_ENCODE, 24'd0, 24'd1, 24'hFF_FFFF);
    send_item(OP_FINISH, '0, '0, '0);
  endtask

  task automatic test_zero_total();
    send_item(OP_ENCODE, 24'hFF_FFFF, 24'hFF_FFFF, 24'd0);
    send_item(OP_ENCODE, 24'd0, 24'd0, 24'd0);
  endtask

  // empty interval leaves range at zero, so the next encode has no quotient
  task automatic test_empty_interval();
    send_item(OP_START, '0, '0, '0);
    send_item(OP_ENCODE, 24'd5, 24'd5, 24'd100);
    send_item(OP_ENCODE, 24'd1, 24'd2, 24'd3);
    send_item(OP_START, '0, '0, '0);
  endtask

  task automatic test_inverted_interval();
    send_item(OP_ENCODE, 24'd200, 24'd100, 24'd300);
    send_item(OP_FINISH, '0, '0, '0);
  endtask

  // sym_low above the total: low wraps; upper-interval branch, then a wrapped width
  task automatic test_oversized_low();
    send_item(OP_ENCODE, 24'hFF_FFFF, 24'hFF_FFFF, 24'h80_0000);
    send_item(OP_ENCODE, 24'hFF_FFFF, 24'd3, 24'd10);
  endtask

  task automatic test_top_interval();
    send_item(OP_ENCODE, 24'd0, 24'hFF_FFFF, 24'hFF_FFFF);
    send_item(OP_ENCODE, 24'd1, 24'hFF_FFFF, 24'd2);
  endtask

  task automatic test_unknown_op();
    send_item(OP_UNKNOWN, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF);
  endtask

  // repeated top symbols keep low above 0xFF000000: pending 0xFF run builds up
  task automatic test_pending_run();
    send_item(OP_START, '0, '0, '0);
    repeat (5) send_item(OP_ENCODE, 24'd255, 24'd256, 24'd256);
    send_item(OP_FINISH, '0, '0, '0);
  endtask

  // mostly well-formed frames with random symbols, some noise and broken frames
  task automatic test_random_frames();
    int nsym;
    while (items_sent < ITEM_TARGET) begin
      sender_eager = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 99) < 15) begin
        send_item(2'($urandom_range(0, 3)), 24'($urandom()), 24'($urandom()),
                  24'($urandom()));
      end else begin
        if ($urandom_range(0, 9) != 0)
          send_item(OP_START, 24'($urandom()), 24'($urandom()), 24'($urandom()));
        nsym = $urandom_range(1, 12);
        repeat (nsym) send_symbol();
        if ($urandom_range(0, 9) != 0)
          send_item(OP_FINISH, 24'($urandom()), 24'($urandom()), 24'($urandom()));
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_basic_frame();
    test_zero_total();
    test_empty_interval();
    test_inverted_interval();
    test_oversized_low();
    test_top_interval();
    test_unknown_op();
    test_pending_run();
    test_random_frames();
    s_tvalid <= 1'b0;
    while (pred_runs.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
`default_nettype wire
